// ----- hw/rtl/idt_pkg.sv -----
package idt_pkg;

  localparam int POSITION_BITS = 24;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] CHAR_STAR      = 8'h2A;
  localparam logic [7:0] CHAR_LPAREN    = 8'h28;
  localparam logic [7:0] CHAR_RPAREN    = 8'h29;
  localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
  localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_VT        = 8'h0B;
  localparam logic [7:0] CHAR_FF        = 8'h0C;
  localparam logic [7:0] CHAR_CR        = 8'h0D;

  typedef enum logic [2:0] {
    TOK_EMPH    = 3'd0,
    TOK_STRONG  = 3'd1,
    TOK_PAREN   = 3'd2,
    TOK_REF     = 3'd3,
    TOK_COMMENT = 3'd4
  } token_kind_e;

  typedef struct packed {
    token_kind_e kind;
    logic        opens;
  } tok_attr_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
               (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
  endfunction

endpackage

// ----- hw/rtl/idt_if.sv -----
interface idt_in_if import idt_pkg::*; #(
  parameter int PosBits = POSITION_BITS
);
  logic               valid;
  logic               ready;
  logic [7:0]         char_byte;
  logic [PosBits-1:0] position;
  logic               line_last;

  modport source (output valid, char_byte, position, line_last, input ready);
  modport sink   (input valid, char_byte, position, line_last, output ready);
endinterface

interface idt_out_if import idt_pkg::*; #(
  parameter int PosBits = POSITION_BITS
);
  logic               valid;
  logic               ready;
  logic [2:0]         token_kind;
  logic               opens;
  logic [PosBits-1:0] start_pos;
  logic [PosBits-1:0] end_pos;
  logic               last_of_run;

  modport source (output valid, token_kind, opens, start_pos, end_pos, last_of_run,
                  input ready);
  modport sink   (input valid, token_kind, opens, start_pos, end_pos, last_of_run,
                  output ready);
endinterface

interface idt_cfg_if;
  logic valid;
  logic ready;
  logic parens_enabled;

  modport source (output valid, parens_enabled, input ready);
  modport sink   (input valid, parens_enabled, output ready);
endinterface

// ----- hw/rtl/idt_front.sv -----
module idt_front import idt_pkg::*; #(
  parameter int PosBits = POSITION_BITS,
  localparam int TokBits = $bits(tok_attr_t) + 2 * PosBits,
  localparam int EntryBits = 2 * TokBits + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  idt_in_if.sink               byte_i,
  idt_cfg_if.sink              cfg_i,
  output logic                 push_o,
  output logic [EntryBits-1:0] push_data_o,
  input  logic                 full_i
);

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_STAR,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_IGNORE
  } mode_e;

  mode_e              mode_q, mode_d;
  logic [PosBits-1:0] held_q, held_d;
  logic               esc_q, esc_d;
  logic               parens_q;

  logic               accept;
  logic [7:0]         c;
  logic               last;
  logic [PosBits-1:0] pos, pos_inc, held_inc;

  logic               escaped;
  logic               p_tok;
  tok_attr_t          p_attr;
  mode_e              p_mode;
  logic               p_hold;

  logic               t0_v, t1_v;
  tok_attr_t          a0, a1;
  logic [PosBits-1:0] s0, e0;

  assign cfg_i.ready  = 1'b1;
  assign byte_i.ready = !full_i;
  assign accept       = byte_i.valid && byte_i.ready;

  assign c        = byte_i.char_byte;
  assign last     = byte_i.line_last;
  assign pos      = byte_i.position;
  assign pos_inc  = pos + 1'b1;
  assign held_inc = held_q + 1'b1;

  // A backslash escapes only in plain scanning; a byte after a pending star
  // or slash is never escaped.
  assign escaped = (mode_q == MODE_NORMAL) && esc_q;

  // Plain scan of the current byte.
  always_comb begin
    p_tok  = 1'b0;
    p_attr = '{kind: TOK_EMPH, opens: 1'b1};
    p_mode = MODE_NORMAL;
    p_hold = 1'b0;
    if (!escaped) begin
      unique case (c)
        CHAR_STAR: begin
          if (last) begin
            p_tok = 1'b1;
          end else begin
            p_mode = MODE_STAR;
            p_hold = 1'b1;
          end
        end
        CHAR_LPAREN: begin
          p_tok  = parens_q;
          p_attr = '{kind: TOK_PAREN, opens: 1'b1};
        end
        CHAR_RPAREN: begin
          p_tok  = parens_q;
          p_attr = '{kind: TOK_PAREN, opens: 1'b0};
        end
        CHAR_LBRACKET: begin
          p_tok  = 1'b1;
          p_attr = '{kind: TOK_REF, opens: 1'b1};
        end
        CHAR_RBRACKET: begin
          p_tok  = 1'b1;
          p_attr = '{kind: TOK_REF, opens: 1'b0};
        end
        CHAR_SLASH: begin
          if (!last) begin
            p_mode = MODE_SLASH;
            p_hold = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    t0_v   = 1'b0;
    t1_v   = 1'b0;
    a0     = p_attr;
    a1     = p_attr;
    s0     = pos;
    e0     = pos_inc;
    mode_d = mode_q;
    held_d = held_q;
    unique case (mode_q)
      MODE_STAR: begin
        if (c == CHAR_STAR) begin
          t0_v   = 1'b1;
          a0     = '{kind: TOK_STRONG, opens: 1'b1};
          s0     = held_q;
          mode_d = MODE_NORMAL;
        end else begin
          // flush the held star, then scan this byte
          t0_v   = 1'b1;
          a0     = '{kind: TOK_EMPH, opens: 1'b1};
          s0     = held_q;
          e0     = held_inc;
          t1_v   = p_tok;
          mode_d = p_mode;
          if (p_hold) begin
            held_d = pos;
          end
        end
      end
      MODE_SLASH: begin
        if (c == CHAR_SLASH) begin
          mode_d = MODE_COMMENT;
          t0_v   = last;
          a0     = '{kind: TOK_COMMENT, opens: 1'b1};
          s0     = held_q;
        end else begin
          t0_v   = p_tok;
          mode_d = p_mode;
          if (p_hold) begin
            held_d = pos;
          end
        end
      end
      MODE_COMMENT: begin
        a0 = '{kind: TOK_COMMENT, opens: 1'b1};
        s0 = held_q;
        if (!is_space(c)) begin
          t0_v   = 1'b1;
          e0     = pos;
          mode_d = MODE_IGNORE;
        end else begin
          t0_v = last;
        end
      end
      MODE_IGNORE: ;
      MODE_NORMAL: begin
        t0_v   = p_tok;
        mode_d = p_mode;
        if (p_hold) begin
          held_d = pos;
        end
      end
    endcase
    if (last) begin
      mode_d = MODE_NORMAL;
    end
    esc_d = !last && (c == CHAR_BACKSLASH);
  end

  // The second token is always the current byte's single-byte token.
  assign push_o      = accept && t0_v;
  assign push_data_o = {t1_v, a1, pos, pos_inc, a0, s0, e0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NORMAL;
      held_q   <= '0;
      esc_q    <= 1'b0;
      parens_q <= 1'b1;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        held_q <= held_d;
        esc_q  <= esc_d;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        parens_q <= cfg_i.parens_enabled;
      end
    end
  end

endmodule

// ----- hw/rtl/idt_fifo.sv -----
module idt_fifo import idt_pkg::*; #(
  parameter int Width = 1,
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             valid_o
);

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_q;
  logic               do_push, do_pop;

  function automatic logic [PtrBits-1:0] ptr_inc(input logic [PtrBits-1:0] p);
    ptr_inc = (p == PtrBits'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = (cnt_q == CntBits'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/idt_back.sv -----
module idt_back import idt_pkg::*; #(
  parameter int PosBits = POSITION_BITS,
  localparam int TokBits = $bits(tok_attr_t) + 2 * PosBits,
  localparam int EntryBits = 2 * TokBits + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 entry_valid_i,
  input  logic [EntryBits-1:0] entry_i,
  output logic                 pop_o,
  idt_out_if.source            token_o
);

  logic               out_valid_q;
  logic [TokBits-1:0] tok_q;
  logic               last_q;
  logic               pend_q;
  logic [TokBits-1:0] tok1_q;
  logic               out_free;
  logic               two;
  tok_attr_t          attr;

  assign out_free = !out_valid_q || token_o.ready;
  assign pop_o    = out_free && !pend_q && entry_valid_i;
  assign two      = entry_i[EntryBits-1];

  assign attr                = tok_attr_t'(tok_q[TokBits-1:2*PosBits]);
  assign token_o.valid       = out_valid_q;
  assign token_o.token_kind  = attr.kind;
  assign token_o.opens       = attr.opens;
  assign token_o.start_pos   = tok_q[2*PosBits-1:PosBits];
  assign token_o.end_pos     = tok_q[PosBits-1:0];
  assign token_o.last_of_run = last_q;

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_q) begin
        tok_q  <= tok1_q;
        last_q <= 1'b1;
      end else if (entry_valid_i) begin
        tok_q  <= entry_i[TokBits-1:0];
        tok1_q <= entry_i[2*TokBits-1:TokBits];
        last_q <= !two;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (out_free) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else begin
        out_valid_q <= entry_valid_i;
        pend_q      <= entry_valid_i && two;
      end
    end
  end

endmodule

// ----- hw/rtl/inline_delimiter_tokenizer_top.sv -----
// Inline delimiter tokenizer: takes one byte of a trimmed text line per cycle
// and issues emphasis, strong, parenthetical, reference and comment tokens.
// A byte is taken every cycle as long as the two-entry token queue between the
// scanner and the token issue stage has room; a token passes through that queue
// and then the output register. A byte that yields two tokens (a flushed star
// followed by its own token) has them issued one after the other from the
// single-token output register, which lowers the sustained byte rate. The
// parentheses enable is written through the configuration channel, which is
// always ready.
module inline_delimiter_tokenizer_top import idt_pkg::*; #(
  parameter int PosBits    = POSITION_BITS,
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  idt_cfg_if.sink   cfg_i,
  idt_in_if.sink    byte_i,
  idt_out_if.source token_o
);

  localparam int TokBits   = $bits(tok_attr_t) + 2 * PosBits;
  localparam int EntryBits = 2 * TokBits + 1;

  logic                 push;
  logic [EntryBits-1:0] push_data;
  logic                 full;
  logic                 pop;
  logic [EntryBits-1:0] pop_data;
  logic                 entry_valid;

  idt_front #(
    .PosBits (PosBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .cfg_i       (cfg_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  idt_fifo #(
    .Width (EntryBits),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .valid_o     (entry_valid)
  );

  idt_back #(
    .PosBits (PosBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (entry_valid),
    .entry_i       (pop_data),
    .pop_o         (pop),
    .token_o       (token_o)
  );

endmodule

// ----- tb/sv/idt_tb_pkg.sv -----
`timescale 1ns / 1ps

package idt_tb_pkg;
  import idt_pkg::*;

  typedef enum logic [2:0] {
    SCAN_NORMAL,
    SCAN_STAR,
    SCAN_SLASH,
    SCAN_COMMENT,
    SCAN_IGNORE
  } scan_mode_e;

  typedef struct packed {
    token_kind_e              kind;
    logic                     opens;
    logic [POSITION_BITS-1:0] start_pos;
    logic [POSITION_BITS-1:0] end_pos;
    logic                     last_of_run;
  } token_t;

  class token_scoreboard;
    token_t                   expected_q[$];
    token_t                   run_q[$];
    scan_mode_e               mode;
    logic [POSITION_BITS-1:0] held_pos;
    logic                     after_bs;
    logic                     parens_en;
    int                       mismatches;
    int                       tokens_checked;
    int                       strong_seen;
    int                       comment_seen;
    int                       pair_bytes;

    function new();
      mode           = SCAN_NORMAL;
      held_pos       = '0;
      after_bs       = 1'b0;
      parens_en      = 1'b1;
      mismatches     = 0;
      tokens_checked = 0;
      strong_seen    = 0;
      comment_seen   = 0;
      pair_bytes     = 0;
    endfunction

    function void set_parens(input logic v);
      parens_en = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [POSITION_BITS-1:0] next_pos(input logic [POSITION_BITS-1:0] p);
      logic [POSITION_BITS-1:0] n;
      n = p + 1'b1;
      return n;
    endfunction

    function logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
             (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
    endfunction

    function void add_token(input token_kind_e k, input logic op,
                            input logic [POSITION_BITS-1:0] s,
                            input logic [POSITION_BITS-1:0] e);
      token_t t;
      t.kind        = k;
      t.opens       = op;
      t.start_pos   = s;
      t.end_pos     = e;
      t.last_of_run = 1'b0;
      run_q.push_back(t);
    endfunction

    // Scan a byte from normal mode; a star or slash not at the line end becomes pending here.
    function void scan_fresh(input logic [7:0] c, input logic [POSITION_BITS-1:0] p,
                             input logic last, input logic escaped);
      mode = SCAN_NORMAL;
      if (escaped) return;
      case (c)
        CHAR_STAR: begin
          if (last) add_token(TOK_EMPH, 1'b1, p, next_pos(p));
          else begin
            mode     = SCAN_STAR;
            held_pos = p;
          end
        end
        CHAR_LPAREN:   if (parens_en) add_token(TOK_PAREN, 1'b1, p, next_pos(p));
        CHAR_RPAREN:   if (parens_en) add_token(TOK_PAREN, 1'b0, p, next_pos(p));
        CHAR_LBRACKET: add_token(TOK_REF, 1'b1, p, next_pos(p));
        CHAR_RBRACKET: add_token(TOK_REF, 1'b0, p, next_pos(p));
        CHAR_SLASH: begin
          if (!last) begin
            mode     = SCAN_SLASH;
            held_pos = p;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_byte(input logic [7:0] c, input logic [POSITION_BITS-1:0] p,
                            input logic last);
      run_q.delete();
      case (mode)
        SCAN_STAR: begin
          if (c == CHAR_STAR) begin
            add_token(TOK_STRONG, 1'b1, held_pos, next_pos(p));
            mode = SCAN_NORMAL;
          end else begin
            // flush the held star, then scan this byte unescaped
            add_token(TOK_EMPH, 1'b1, held_pos, next_pos(held_pos));
            scan_fresh(c, p, last, 1'b0);
          end
        end
        SCAN_SLASH: begin
          if (c == CHAR_SLASH) begin
            mode = SCAN_COMMENT;
            if (last) add_token(TOK_COMMENT, 1'b1, held_pos, next_pos(p));
          end else begin
            scan_fresh(c, p, last, 1'b0);
          end
        end
        SCAN_COMMENT: begin
          if (!is_blank(c)) begin
            add_token(TOK_COMMENT, 1'b1, held_pos, p);
            mode = SCAN_IGNORE;
          end else if (last) begin
            add_token(TOK_COMMENT, 1'b1, held_pos, next_pos(p));
          end
        end
        SCAN_IGNORE: ;
        default: scan_fresh(c, p, last, after_bs);
      endcase
      if (last) begin
        mode     = SCAN_NORMAL;
        after_bs = 1'b0;
      end else begin
        after_bs = (c == CHAR_BACKSLASH);
      end
      if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
      if (run_q.size() > 1) pair_bytes++;
      foreach (run_q[i]) expected_q.push_back(run_q[i]);
    endfunction

    task report(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_token(input token_t got);
      token_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("token kind %0d start %0h with nothing expected",
                         got.kind, got.start_pos));
        return;
      end
      exp = expected_q.pop_front();
      if (got.kind !== exp.kind)
        report($sformatf("token %0d: kind %0d, expected %0d",
                         tokens_checked, got.kind, exp.kind));
      if (got.opens !== exp.opens)
        report($sformatf("token %0d: opens %0b, expected %0b",
                         tokens_checked, got.opens, exp.opens));
      if (got.start_pos !== exp.start_pos)
        report($sformatf("token %0d: start_pos %0h, expected %0h",
                         tokens_checked, got.start_pos, exp.start_pos));
      if (got.end_pos !== exp.end_pos)
        report($sformatf("token %0d: end_pos %0h, expected %0h",
                         tokens_checked, got.end_pos, exp.end_pos));
      if (got.last_of_run !== exp.last_of_run)
        report($sformatf("token %0d: last_of_run %0b, expected %0b",
                         tokens_checked, got.last_of_run, exp.last_of_run));
      if (exp.kind == TOK_STRONG) strong_seen++;
      if (exp.kind == TOK_COMMENT) comment_seen++;
      tokens_checked++;
    endtask
  endclass

endpackage

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import idt_pkg::*;
  import idt_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 1700;

  logic clk;
  logic rst_n;
  logic calm;
  int   cycles;
  int   bytes_sent;
  int   lines_sent;
  int   parens_writes;

  logic [7:0] line_buf[$];

  token_scoreboard sb = new();

  idt_cfg_if cfg_if();
  idt_in_if  byte_if();
  idt_out_if token_if();

  inline_delimiter_tokenizer_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .byte_i (byte_if),
    .token_o(token_if)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d tokens outstanding", cycles, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Token sink: stall at random except in the calm phase.
  always @(negedge clk) begin
    token_if.ready <= rst_n && (calm || ($urandom_range(99) >= 33));
  end

  always @(posedge clk) begin
    token_t got;
    if (rst_n && token_if.valid && token_if.ready) begin
      got.kind        = token_kind_e'(token_if.token_kind);
      got.opens       = token_if.opens;
      got.start_pos   = token_if.start_pos;
      got.end_pos     = token_if.end_pos;
      got.last_of_run = token_if.last_of_run;
      sb.check_token(got);
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic [POSITION_BITS-1:0] p,
                           input logic last);
    while (!calm && ($urandom_range(99) < 33)) begin
      byte_if.valid <= 1'b0;
      @(negedge clk);
    end
    byte_if.valid     <= 1'b1;
    byte_if.char_byte <= c;
    byte_if.position  <= p;
    byte_if.line_last <= last;
    do @(posedge clk); while (!byte_if.ready);
    sb.note_byte(c, p, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every expected token has been taken.
  task automatic hold_until_drained();
    byte_if.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic settle();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_parens(input logic v);
    cfg_if.valid          <= 1'b1;
    cfg_if.parens_enabled <= v;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_parens(v);
    parens_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_line(input logic [POSITION_BITS-1:0] base, input logic jumpy,
                           input int pause_pct);
    logic [POSITION_BITS-1:0] p;
    p = base;
    foreach (line_buf[i]) begin
      if ($urandom_range(99) < pause_pct) hold_until_drained();
      if (jumpy && i > 0) p = POSITION_BITS'($urandom);
      send_byte(line_buf[i], p, i == line_buf.size() - 1);
      p = p + 1'b1;
    end
    lines_sent++;
  endtask

  task automatic send_text(input string s, input logic [POSITION_BITS-1:0] base);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line(base, 1'b0, 0);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(5))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      2:       return CHAR_LF;
      3:       return CHAR_VT;
      4:       return CHAR_FF;
      default: return CHAR_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_delim();
    case ($urandom_range(6))
      0:       return CHAR_STAR;
      1:       return CHAR_LPAREN;
      2:       return CHAR_RPAREN;
      3:       return CHAR_LBRACKET;
      4:       return CHAR_RBRACKET;
      5:       return CHAR_SLASH;
      default: return CHAR_BACKSLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'h61 + 8'($urandom_range(25));
    return c;
  endfunction

  function automatic void add_fragment();
    case ($urandom_range(9))
      0: repeat ($urandom_range(1, 4)) line_buf.push_back(pick_letter());
      1: begin
        line_buf.push_back(CHAR_STAR);
        if ($urandom_range(1)) line_buf.push_back(CHAR_STAR);
      end
      2: line_buf.push_back($urandom_range(1) ? CHAR_LPAREN : CHAR_RPAREN);
      3: line_buf.push_back($urandom_range(1) ? CHAR_LBRACKET : CHAR_RBRACKET);
      4: begin
        // comment opener, blanks, then whatever follows gets ignored
        line_buf.push_back(CHAR_SLASH);
        line_buf.push_back(CHAR_SLASH);
        repeat ($urandom_range(0, 3)) line_buf.push_back(pick_blank());
        if ($urandom_range(3) != 0) line_buf.push_back(8'($urandom_range(255)));
        repeat ($urandom_range(0, 4)) line_buf.push_back(pick_delim());
      end
      5: begin
        line_buf.push_back(CHAR_SLASH);
        line_buf.push_back($urandom_range(1) ? pick_delim() : pick_letter());
      end
      6: begin
        line_buf.push_back(CHAR_BACKSLASH);
        line_buf.push_back(pick_delim());
      end
      7: line_buf.push_back(8'($urandom_range(255)));
      8: line_buf.push_back(pick_blank());
      default: line_buf.push_back(pick_delim());
    endcase
  endfunction

  function automatic logic [POSITION_BITS-1:0] pick_base();
    logic [POSITION_BITS-1:0] b;
    case ($urandom_range(9))
      0:       b = {POSITION_BITS{1'b1}} - POSITION_BITS'($urandom_range(15));
      1:       b = POSITION_BITS'($urandom_range(15));
      default: b = POSITION_BITS'($urandom);
    endcase
    return b;
  endfunction

  initial begin
    int phase;
    int target;

    rst_n                 = 1'b0;
    calm                  = 1'b0;
    cycles                = 0;
    bytes_sent            = 0;
    lines_sent            = 0;
    parens_writes         = 0;
    cfg_if.valid          = 1'b0;
    cfg_if.parens_enabled = 1'b1;
    byte_if.valid         = 1'b0;
    byte_if.char_byte     = '0;
    byte_if.position      = '0;
    byte_if.line_last     = 1'b0;
    token_if.ready        = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_parens(1'b1);
    send_text("*", {POSITION_BITS{1'b1}});
    line_buf.delete();
    line_buf.push_back(CHAR_STAR);
    line_buf.push_back(CHAR_STAR);
    send_line(24'h000100, 1'b0, 100);
    send_text("*[", 24'h800000);
    send_text("(])", 24'h7FFFFE);
    send_text("/a", 24'h000010);
    send_text("//", {POSITION_BITS{1'b1}});
    send_text("// x*", 24'h123456);
    send_text("\\*", 24'h000020);
    send_text("\\\\*", 24'h000030);
    send_byte(8'hFF, 24'h555555, 1'b1);
    settle();
    write_parens(1'b0);
    send_text("()", 24'hAAAAAA);
    send_text("/", 24'h000040);
    settle();

    target = bytes_sent + RANDOM_BYTES;
    phase  = 0;
    while (bytes_sent < target) begin
      calm = (phase == 2);
      repeat ($urandom_range(10, 30)) begin
        line_buf.delete();
        repeat ($urandom_range(1, 8)) add_fragment();
        send_line(pick_base(), $urandom_range(9) == 0, 2);
      end
      settle();
      write_parens(phase == 0 ? 1'b1 : 1'($urandom_range(1)));
      phase++;
    end
    calm = 1'b0;
    settle();

    if (sb.pending() != 0)
      sb.report($sformatf("%0d tokens never issued", sb.pending()));
    $display("Sent %0d bytes in %0d lines over %0d phases, %0d parens-enable writes",
             bytes_sent, lines_sent, phase, parens_writes);
    $display("Checked %0d tokens: %0d strong, %0d comment, %0d bytes giving two tokens",
             sb.tokens_checked, sb.strong_seen, sb.comment_seen, sb.pair_bytes);
    if (sb.mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
